// ----- design/thread_state_scheduler_macros.svh -----
// Assertion macros for the thread state scheduler.
// Included by the top level; assertions compile away when NO_ASSERTIONS is set.
`ifndef THREAD_STATE_SCHEDULER_MACROS_SVH
`define THREAD_STATE_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define TSS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TSS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/tss_pkg.sv -----
// Shared types and constants for the thread state scheduler.
// No dependencies; used by the channel interfaces, the join table and the top level.
package tss_pkg;

  localparam int CMD_W    = 3;
  localparam int TID_W    = 4;
  localparam int MASK_W   = 16;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CMD_W-1:0] CMD_CREATE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_JOIN      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAIT      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SIGNAL    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BROADCAST = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_READY = 2'd2;

  // Register index, decoded from the word-address bit of paddr.
  localparam logic REG_THREAD_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] THREAD_LIMIT_RESET = 5'd16;

  // Join table write operation.
  typedef struct packed {
    logic clear;
    logic set;
  } jt_op_t;

endpackage

// ----- design/tss_channels.sv -----
// Valid/ready channel interfaces for scheduler commands and responses.
// Depends on tss_pkg for field widths.
interface tss_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tss_pkg::CMD_W-1:0]    command;
  logic [tss_pkg::TID_W-1:0]    target_thread;
  logic [tss_pkg::MASK_W-1:0]   waiter_mask_in;

  modport source (output valid, command, target_thread, waiter_mask_in, input ready);
  modport sink (input valid, command, target_thread, waiter_mask_in, output ready);
endinterface

interface tss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::STATUS_W-1:0]  status;
  logic [tss_pkg::TID_W-1:0]     created_thread;
  logic [tss_pkg::MASK_W-1:0]    waiter_mask_out;
  logic [tss_pkg::TID_W-1:0]     running_thread;
  logic [tss_pkg::MASK_W-1:0]    ready_bits;

  modport source (output valid, status, created_thread, waiter_mask_out, running_thread,
                  ready_bits, input ready);
  modport sink (input valid, status, created_thread, waiter_mask_out, running_thread,
                ready_bits, output ready);
endinterface

// ----- design/tss_join_table.sv -----
// Per-slot join target table with valid bits and one read port.
// Depends on tss_pkg for the write operation struct.
module tss_join_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_idx,
  output logic                          rd_valid,
  output logic [$clog2(SLOT_COUNT)-1:0] rd_target,
  input  tss_pkg::jt_op_t               wr_op,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_idx,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_target
);

  localparam int IDW = $clog2(SLOT_COUNT);

  logic [SLOT_COUNT-1:0] valid;
  logic [IDW-1:0]        target [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_op.set) begin
      valid[wr_idx] <= 1'b1;
    end else if (wr_op.clear) begin
      valid[wr_idx] <= 1'b0;
    end
  end

  // Targets need no reset: an entry is only read while its valid bit is set.
  always_ff @(posedge clk) begin
    if (wr_op.set) begin
      target[wr_idx] <= wr_target;
    end
  end

  assign rd_valid  = valid[rd_idx];
  assign rd_target = target[rd_idx];

endmodule

// ----- design/thread_state_scheduler.sv -----
// Thread state scheduler top level: command sequencer, thread masks and APB register.
// Depends on tss_pkg, tss_channels (tss_cmd_if, tss_rsp_if), tss_join_table and
// thread_state_scheduler_macros.svh.
//
// This block keeps the bookkeeping of a small round-robin thread manager: which
// slots are allocated, ready and finished, which thread runs, and whom each
// thread waits to join. Every command transaction yields exactly one response
// transaction. Commands are handled one at a time by a sequencer around a single
// slot compare unit that looks at one slot per cycle. A command is taken, then,
// as needed, a slot scan over the slots below L (L being the effective thread
// limit) finds the lowest free slot, joiner, duplicate join or waiter; a reduce
// step brings current + 1 below L by repeated subtraction of L and so sets the
// round-robin start; a pick over up to L slots finds the next ready thread; and
// the response register is written. The last step waits for as long as the
// previous response still waits for its consumer. The next command is accepted
// as soon as the sequencer is idle, even while the previous response still
// waits for its consumer. The thread limit lives in one APB register at byte
// address 0 and is only to be written while no command is in flight. There is no
// clearing pass: join table entries carry valid bits cleared by reset.
`include "thread_state_scheduler_macros.svh"

module thread_state_scheduler #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  tss_cmd_if.sink                           cmd,
  tss_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tss_pkg::PADDR_W-1:0]       paddr,
  input  logic [tss_pkg::PDATA_W-1:0]       pwdata,
  output logic [tss_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int IDW   = $clog2(SLOT_COUNT);
  localparam int LIM_W = $clog2(SLOT_COUNT + 1);
  localparam logic [SLOT_COUNT-1:0] ONE = SLOT_COUNT'(1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MOD  = 5'b00100,
    S_PICK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // Thread state.
  logic [SLOT_COUNT-1:0] alloc_mask, alloc_next;
  logic [SLOT_COUNT-1:0] ready_mask, ready_next;
  logic [SLOT_COUNT-1:0] fin_mask, fin_next;
  logic [IDW-1:0]        cur, cur_next;
  logic [tss_pkg::LIMIT_W-1:0] thread_limit;

  // Command in flight.
  logic [tss_pkg::CMD_W-1:0]    cmd_r, cmd_next;
  logic [tss_pkg::TID_W-1:0]    tgt_r, tgt_next;
  logic [tss_pkg::MASK_W-1:0]   mask_r, mask_next;
  logic [tss_pkg::STATUS_W-1:0] status_r, status_next;
  logic [IDW-1:0]               created_r, created_next;

  // Sequencer counters.
  logic [IDW-1:0]   scan_idx, scan_next;
  logic [LIM_W-1:0] mod_r, mod_next;
  logic [IDW-1:0]   pick_idx, pidx_next;
  logic [LIM_W-1:0] pick_cnt, pcnt_next;

  logic load_rsp;

  // Effective limit: zero acts as one, anything above the slot count as the slot count.
  logic [5:0]       limit_wide;
  logic [LIM_W-1:0] lim;
  logic [IDW-1:0]   lim_last;

  always_comb begin
    limit_wide = 6'(thread_limit);
    if (limit_wide == 6'd0) begin
      lim = LIM_W'(1);
    end else if (limit_wide > 6'(SLOT_COUNT)) begin
      lim = LIM_W'(SLOT_COUNT);
    end else begin
      lim = LIM_W'(limit_wide);
    end
  end

  assign lim_last = IDW'(lim - LIM_W'(1));

  // Join table.
  tss_pkg::jt_op_t jt_op;
  logic [IDW-1:0]  jt_wr_idx;
  logic [IDW-1:0]  jt_wr_target;
  logic            jt_rd_valid;
  logic [IDW-1:0]  jt_rd_target;

  tss_join_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_join_table (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (scan_idx),
    .rd_valid  (jt_rd_valid),
    .rd_target (jt_rd_target),
    .wr_op     (jt_op),
    .wr_idx    (jt_wr_idx),
    .wr_target (jt_wr_target)
  );

  // Bit selects used by the sequencer.
  logic [SLOT_COUNT-1:0]      cur_bit;
  logic [SLOT_COUNT-1:0]      idx_bit;
  logic [SLOT_COUNT-1:0]      tgt_bit;
  logic [tss_pkg::MASK_W-1:0] cur_bit16;
  logic [tss_pkg::MASK_W-1:0] idx_bit16;
  logic                       join_bad;
  logic                       scan_hit;
  logic                       scan_last;

  assign cur_bit   = ONE << cur;
  assign idx_bit   = ONE << scan_idx;
  assign tgt_bit   = ONE << tgt_r;
  assign cur_bit16 = 16'd1 << cur;
  assign idx_bit16 = 16'd1 << scan_idx;
  assign scan_last = (scan_idx == lim_last);

  // Checks on a join that need no table scan: target in range, not the caller,
  // and allocated.
  assign join_bad = (6'(cmd.target_thread) >= 6'(lim)) ||
                    (5'(cmd.target_thread) == 5'(cur)) ||
                    !(|(alloc_mask & (ONE << cmd.target_thread)));

  // The shared slot compare: what counts as a hit depends on the command.
  always_comb begin
    unique case (cmd_r)
      tss_pkg::CMD_CREATE:    scan_hit = !(|(alloc_mask & idx_bit));
      tss_pkg::CMD_EXIT:      scan_hit = jt_rd_valid && (jt_rd_target == cur);
      tss_pkg::CMD_JOIN:      scan_hit = jt_rd_valid && (jt_rd_target == IDW'(tgt_r));
      tss_pkg::CMD_SIGNAL,
      tss_pkg::CMD_BROADCAST: scan_hit = |(mask_r & idx_bit16);
      default:                scan_hit = 1'b0;
    endcase
  end

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    alloc_next   = alloc_mask;
    ready_next   = ready_mask;
    fin_next     = fin_mask;
    cur_next     = cur;
    cmd_next     = cmd_r;
    tgt_next     = tgt_r;
    mask_next    = mask_r;
    status_next  = status_r;
    created_next = created_r;
    scan_next    = scan_idx;
    mod_next     = mod_r;
    pidx_next    = pick_idx;
    pcnt_next    = pick_cnt;
    jt_op        = '0;
    jt_wr_idx    = scan_idx;
    jt_wr_target = IDW'(tgt_r);
    load_rsp     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          cmd_next     = cmd.command;
          tgt_next     = cmd.target_thread;
          mask_next    = cmd.waiter_mask_in;
          status_next  = tss_pkg::ST_OK;
          created_next = '0;
          scan_next    = '0;
          mod_next     = LIM_W'(cur) + LIM_W'(1);
          unique case (cmd.command)
            tss_pkg::CMD_CREATE: begin
              // Rejected unless the scan finds a free slot.
              status_next = tss_pkg::ST_REJECT;
              state_next  = S_SCAN;
            end
            tss_pkg::CMD_EXIT: begin
              ready_next = ready_mask & ~cur_bit;
              state_next = S_SCAN;
            end
            tss_pkg::CMD_JOIN: begin
              if (join_bad) begin
                status_next = tss_pkg::ST_REJECT;
                state_next  = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            tss_pkg::CMD_TICK: begin
              state_next = S_MOD;
            end
            tss_pkg::CMD_WAIT: begin
              mask_next  = cmd.waiter_mask_in | cur_bit16;
              ready_next = ready_mask & ~cur_bit;
              state_next = S_MOD;
            end
            tss_pkg::CMD_SIGNAL,
            tss_pkg::CMD_BROADCAST: begin
              state_next = S_SCAN;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_hit) begin
          unique case (cmd_r)
            tss_pkg::CMD_CREATE: begin
              alloc_next   = alloc_mask | idx_bit;
              ready_next   = ready_mask | idx_bit;
              jt_op.clear  = 1'b1;
              created_next = scan_idx;
              status_next  = tss_pkg::ST_OK;
              state_next   = S_DONE;
            end
            tss_pkg::CMD_EXIT: begin
              // Lowest joiner wakes and the exiting slot is freed.
              ready_next  = ready_mask | idx_bit;
              alloc_next  = alloc_mask & ~cur_bit;
              jt_op.clear = 1'b1;
              state_next  = S_MOD;
            end
            tss_pkg::CMD_JOIN: begin
              // Someone already joins this target.
              status_next = tss_pkg::ST_REJECT;
              state_next  = S_DONE;
            end
            tss_pkg::CMD_SIGNAL: begin
              ready_next = ready_mask | idx_bit;
              mask_next  = mask_r & ~idx_bit16;
              state_next = S_DONE;
            end
            default: begin
              // Broadcast keeps going through every slot below the limit.
              ready_next = ready_mask | idx_bit;
              mask_next  = mask_r & ~idx_bit16;
              if (scan_last) begin
                state_next = S_DONE;
              end else begin
                scan_next = scan_idx + IDW'(1);
              end
            end
          endcase
        end else if (scan_last) begin
          unique case (cmd_r)
            tss_pkg::CMD_EXIT: begin
              fin_next   = fin_mask | cur_bit;
              state_next = S_MOD;
            end
            tss_pkg::CMD_JOIN: begin
              if (|(fin_mask & tgt_bit)) begin
                // Target already finished: reap it, caller keeps running.
                fin_next   = fin_mask & ~tgt_bit;
                alloc_next = alloc_mask & ~tgt_bit;
                state_next = S_DONE;
              end else begin
                ready_next   = ready_mask & ~cur_bit;
                jt_op.set    = 1'b1;
                jt_wr_idx    = cur;
                jt_wr_target = IDW'(tgt_r);
                state_next   = S_MOD;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end else begin
          scan_next = scan_idx + IDW'(1);
        end
      end

      S_MOD: begin
        // Reduce current + 1 modulo the limit by repeated subtraction.
        if (mod_r >= lim) begin
          mod_next = mod_r - lim;
        end else begin
          pidx_next  = IDW'(mod_r);
          pcnt_next  = LIM_W'(1);
          state_next = S_PICK;
        end
      end

      S_PICK: begin
        if (|(ready_mask & (ONE << pick_idx))) begin
          cur_next   = pick_idx;
          state_next = S_DONE;
        end else if (pick_cnt == lim) begin
          // Nobody is ready: the current thread stays.
          status_next = tss_pkg::ST_NO_READY;
          state_next  = S_DONE;
        end else begin
          pcnt_next = pick_cnt + LIM_W'(1);
          pidx_next = (pick_idx == lim_last) ? '0 : pick_idx + IDW'(1);
        end
      end

      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and thread state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      alloc_mask <= ONE;
      ready_mask <= ONE;
      fin_mask   <= '0;
      cur        <= '0;
    end else begin
      state      <= state_next;
      alloc_mask <= alloc_next;
      ready_mask <= ready_next;
      fin_mask   <= fin_next;
      cur        <= cur_next;
    end
  end

  // Working registers of the command in flight.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_next;
    tgt_r     <= tgt_next;
    mask_r    <= mask_next;
    status_r  <= status_next;
    created_r <= created_next;
    scan_idx  <= scan_next;
    mod_r     <= mod_next;
    pick_idx  <= pidx_next;
    pick_cnt  <= pcnt_next;
  end

  // Response register: holds a finished result while the sequencer moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status          <= status_r;
      rsp.created_thread  <= tss_pkg::TID_W'(created_r);
      rsp.waiter_mask_out <= mask_r;
      rsp.running_thread  <= tss_pkg::TID_W'(cur);
      rsp.ready_bits      <= tss_pkg::MASK_W'(ready_mask);
    end
  end

  // APB register port: thread limit; user must write it only while idle, not enforced.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thread_limit <= tss_pkg::THREAD_LIMIT_RESET;
    end else if (psel && penable && pwrite &&
                 (paddr[tss_pkg::PADDR_W-1] == tss_pkg::REG_THREAD_LIMIT)) begin
      thread_limit <= pwdata[tss_pkg::LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[tss_pkg::PADDR_W-1] == tss_pkg::REG_THREAD_LIMIT) ?
                  tss_pkg::PDATA_W'(thread_limit) : '0;

  // Assertions.
  `TSS_ASSERT_NEXT(a_accept_starts_work, clk, rst, cmd.valid && cmd.ready, state != S_IDLE, "accepted command did not start the sequencer")
  `TSS_ASSERT_IMPLIES(a_scan_in_range, clk, rst, state == S_SCAN, LIM_W'(scan_idx) < lim, "slot scan ran past the thread limit")
  `TSS_ASSERT_IMPLIES(a_pick_in_range, clk, rst, state == S_PICK, (LIM_W'(pick_idx) < lim) && (pick_cnt <= lim), "round-robin pick ran past the thread limit")
  `TSS_ASSERT_NEXT(a_rsp_drains, clk, rst, rsp.valid && rsp.ready && !load_rsp, !rsp.valid, "response repeated after its transaction")

endmodule

// ----- test/thread_state_scheduler_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the thread state scheduler: directed and random commands.
// Depends on tss_pkg, tss_channels (tss_cmd_if, tss_rsp_if) and the thread_state_scheduler RTL.
module thread_state_scheduler_tb;
  import tss_pkg::*;

  localparam int SLOTS = 16;
  // Command code 7 is not decoded by the block; it must answer ok and change nothing.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  // The thread limit register is register 0 of the map, so it sits at byte address 0.
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = 3'd0;
  localparam int IDLE_PCT = 11;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 122;
  // Settle time before a register write and after the last response.
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 64;
  // Far more than the slowest command needs, and the response side stalls only briefly,
  // so this many cycles with no transaction is a hang.
  localparam int QUIET_LIMIT = 4000;
  localparam int ROWS = 30;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TID_W-1:0]  target;
    logic [MASK_W-1:0] wmask;
  } sched_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    created;
    logic [MASK_W-1:0]   wmask;
    logic [TID_W-1:0]    running;
    logic [MASK_W-1:0]   ready;
  } sched_result_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [LIMIT_W-1:0] limit;
    sched_cmd_t         item;
    sched_result_t      result;
  } directed_row_t;

  // Directed sequence, starting from the reset state with a limit of 16. Rows marked
  // typed carry a result that follows directly from the rules; the rest are predicted.
  directed_row_t directed_steps [ROWS] = '{
    // A tick with only the main thread ready lands back on the main thread.
    '{ROW_TYPED,   5'd0,  '{CMD_TICK,      4'd0,  16'h0000}, '{ST_OK,     4'd0, 16'h0000, 4'd0, 16'h0001}},
    // A signal with nobody waiting is fine and changes nothing.
    '{ROW_TYPED,   5'd0,  '{CMD_SIGNAL,    4'd0,  16'h0000}, '{ST_OK,     4'd0, 16'h0000, 4'd0, 16'h0001}},
    // Joining yourself, and joining a slot that was never created, are both rejected.
    '{ROW_TYPED,   5'd0,  '{CMD_JOIN,      4'd0,  16'hffff}, '{ST_REJECT, 4'd0, 16'hffff, 4'd0, 16'h0001}},
    '{ROW_TYPED,   5'd0,  '{CMD_JOIN,      4'd15, 16'h0000}, '{ST_REJECT, 4'd0, 16'h0000, 4'd0, 16'h0001}},
    '{ROW_PREDICT, 5'd0,  '{CMD_CREATE,    4'd0,  16'h0000}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_CREATE,    4'd9,  16'h1234}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_WAIT,      4'd0,  16'h0000}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_TICK,      4'd0,  16'h0000}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_SIGNAL,    4'd0,  16'h0001}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_JOIN,      4'd1,  16'h0000}, '0},
    // Thread 1 already has a joiner, so a second join on it is refused.
    '{ROW_TYPED,   5'd0,  '{CMD_JOIN,      4'd1,  16'h0000}, '{ST_REJECT, 4'd0, 16'h0000, 4'd0, 16'h0003}},
    '{ROW_PREDICT, 5'd0,  '{CMD_TICK,      4'd0,  16'h0000}, '0},
    // Exit with a joiner waiting, create into the freed slot, exit with no joiner,
    // then reap the finished thread by a join.
    '{ROW_PREDICT, 5'd0,  '{CMD_EXIT,      4'd0,  16'h0000}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_CREATE,    4'd0,  16'h0000}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_EXIT,      4'd0,  16'h0000}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_JOIN,      4'd2,  16'h0000}, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_WAIT,      4'd0,  16'h0000}, '0},
    // Both threads now wait, so there is nothing left to run.
    '{ROW_TYPED,   5'd0,  '{CMD_WAIT,      4'd0,  16'h0001}, '{ST_NO_READY, 4'd0, 16'h0003, 4'd1, 16'h0000}},
    '{ROW_TYPED,   5'd0,  '{CMD_TICK,      4'd0,  16'h0000}, '{ST_NO_READY, 4'd0, 16'h0000, 4'd1, 16'h0000}},
    '{ROW_PREDICT, 5'd0,  '{CMD_SIGNAL,    4'd0,  16'h0003}, '0},
    '{ROW_TYPED,   5'd0,  '{CMD_BROADCAST, 4'd0,  16'hffff}, '{ST_OK,     4'd0, 16'h0000, 4'd1, 16'hffff}},
    '{ROW_TYPED,   5'd0,  '{CMD_UNUSED,    4'd15, 16'ha5a5}, '{ST_OK,     4'd0, 16'ha5a5, 4'd1, 16'hffff}},
    // With two slots both in use, create has nowhere to go and a join above the limit fails.
    '{ROW_LIMIT,   5'd2,  '0, '0},
    '{ROW_TYPED,   5'd0,  '{CMD_CREATE,    4'd0,  16'h0000}, '{ST_REJECT, 4'd0, 16'h0000, 4'd1, 16'hffff}},
    '{ROW_TYPED,   5'd0,  '{CMD_JOIN,      4'd5,  16'h0000}, '{ST_REJECT, 4'd0, 16'h0000, 4'd1, 16'hffff}},
    '{ROW_PREDICT, 5'd0,  '{CMD_TICK,      4'd0,  16'h0000}, '0},
    // Out-of-range limits: zero behaves as one, anything above the slot count as the count.
    '{ROW_LIMIT,   5'd0,  '0, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_TICK,      4'd0,  16'h0000}, '0},
    '{ROW_LIMIT,   5'd31, '0, '0},
    '{ROW_PREDICT, 5'd0,  '{CMD_EXIT,      4'd0,  16'h0000}, '0}
  };

  // Limits of the random phases, extremes included; 31 and 17 clamp to the slot count.
  logic [LIMIT_W-1:0] limit_plan [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0,
                                              5'd17, 5'd6, 5'd16, 5'd11, 5'd16};

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  tss_cmd_if command_bus();
  tss_rsp_if response_bus();

  thread_state_scheduler u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd     (command_bus),
    .rsp     (response_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Scheduler state as the testbench expects it, updated at each accepted command.
  logic [MASK_W-1:0]  alloc_q    = 16'h0001;
  logic [MASK_W-1:0]  ready_q    = 16'h0001;
  logic [MASK_W-1:0]  finished_q = 16'h0000;
  logic [TID_W-1:0]   running_q  = '0;
  logic [SLOTS-1:0]   joining_q  = '0;
  logic [TID_W-1:0]   join_tgt_q [SLOTS] = '{default: '0};
  logic [LIMIT_W-1:0] limit_q    = THREAD_LIMIT_RESET;

  sched_result_t pending_results [$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;
  // Set while the command valid is low or is being lowered at this edge.
  bit  cmd_parked = 1'b1;

  // Round-robin search starting after the running thread, the running thread last.
  function automatic logic [STATUS_W-1:0] next_runner(input int lim);
    int j;
    for (int k = 1; k <= lim; k++) begin
      j = (int'(running_q) + k) % lim;
      if (ready_q[j]) begin
        running_q = TID_W'(j);
        return ST_OK;
      end
    end
    return ST_NO_READY;
  endfunction

  // Apply one command to the expected state and return the response it should produce.
  function automatic sched_result_t schedule_step(input sched_cmd_t c);
    int lim;
    bit found;
    bit bad;
    logic [TID_W-1:0] cur;
    sched_result_t r;
    lim = (limit_q == 0) ? 1 : ((int'(limit_q) > SLOTS) ? SLOTS : int'(limit_q));
    cur = running_q;
    r = '0;
    r.status = ST_OK;
    r.wmask = c.wmask;
    found = 1'b0;
    case (c.command)
      CMD_CREATE: begin
        r.status = ST_REJECT;
        for (int i = 0; i < lim && !found; i++) begin
          if (!alloc_q[i]) begin
            alloc_q[i] = 1'b1;
            ready_q[i] = 1'b1;
            joining_q[i] = 1'b0;
            join_tgt_q[i] = '0;
            r.created = TID_W'(i);
            r.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      CMD_EXIT: begin
        ready_q[cur] = 1'b0;
        // Only the lowest joiner is woken, and only then is the slot freed.
        for (int i = 0; i < lim && !found; i++) begin
          if (joining_q[i] && join_tgt_q[i] == cur) begin
            ready_q[i] = 1'b1;
            alloc_q[cur] = 1'b0;
            joining_q[i] = 1'b0;
            join_tgt_q[i] = '0;
            found = 1'b1;
          end
        end
        if (!found) finished_q[cur] = 1'b1;
        r.status = next_runner(lim);
      end
      CMD_JOIN: begin
        bad = (int'(c.target) >= lim) || (c.target == cur) || !alloc_q[c.target];
        for (int i = 0; i < lim && !bad; i++) begin
          if (joining_q[i] && join_tgt_q[i] == c.target) bad = 1'b1;
        end
        if (bad) begin
          r.status = ST_REJECT;
        end else if (finished_q[c.target]) begin
          finished_q[c.target] = 1'b0;
          alloc_q[c.target] = 1'b0;
        end else begin
          ready_q[cur] = 1'b0;
          join_tgt_q[cur] = c.target;
          joining_q[cur] = 1'b1;
          r.status = next_runner(lim);
        end
      end
      CMD_TICK: r.status = next_runner(lim);
      CMD_WAIT: begin
        r.wmask[cur] = 1'b1;
        ready_q[cur] = 1'b0;
        r.status = next_runner(lim);
      end
      CMD_SIGNAL, CMD_BROADCAST: begin
        // Waiters at or above the limit stay in the mask untouched.
        for (int i = 0; i < lim && !found; i++) begin
          if (r.wmask[i]) begin
            ready_q[i] = 1'b1;
            r.wmask[i] = 1'b0;
            if (c.command == CMD_SIGNAL) found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.running = running_q;
    r.ready = ready_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Send one command transaction. The expected response is recorded at the edge where
  // the command is accepted. When more is set and no gap is drawn, valid stays high so
  // the next command follows back to back.
  task automatic issue_command(input sched_cmd_t item, input bit typed,
                               input sched_result_t typed_result, input bit more,
                               output sched_result_t predicted);
    if (cmd_parked) begin
      @(posedge clk);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    command_bus.command <= item.command;
    command_bus.target_thread <= item.target;
    command_bus.waiter_mask_in <= item.wmask;
    command_bus.valid <= 1'b1;
    do @(posedge clk); while (!command_bus.ready);
    predicted = schedule_step(item);
    pending_results.push_back(typed ? typed_result : predicted);
    cmd_parked = !more || (!no_idle && $urandom_range(99) < IDLE_PCT);
    if (cmd_parked) command_bus.valid <= 1'b0;
  endtask

  // Write the thread limit once the block has gone idle, then read it back.
  task automatic program_thread_limit(input logic [LIMIT_W-1:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("thread_limit", value, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    limit_q = value;
  endtask

  // Response checking, the response-side stalls and the hang watchdog share one process.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && response_bus.valid && response_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("response transaction with no command outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, response_bus.status);
        check_field("created_thread", want.created, response_bus.created_thread);
        check_field("waiter_mask_out", want.wmask, response_bus.waiter_mask_out);
        check_field("running_thread", want.running, response_bus.running_thread);
        check_field("ready_bits", want.ready, response_bus.ready_bits);
      end
    end
    response_bus.ready <= !rst && (no_idle || ($urandom_range(99) >= IDLE_PCT));
    if ((command_bus.valid && command_bus.ready) || (response_bus.valid && response_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    sched_cmd_t item;
    sched_result_t predicted;
    logic [MASK_W-1:0] waiter_set;
    logic [TID_W-1:0] owned [$];
    int roll;
    bit uses_cv;
    bit more;

    rst <= 1'b1;
    command_bus.valid <= 1'b0;
    command_bus.command <= CMD_TICK;
    command_bus.target_thread <= '0;
    command_bus.waiter_mask_in <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    waiter_set = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the rows in order, programming the limit where a row asks.
    for (int n = 0; n < ROWS; n++) begin
      if (directed_steps[n].kind == ROW_LIMIT) begin
        program_thread_limit(directed_steps[n].limit);
      end else begin
        more = (n + 1 < ROWS) && (directed_steps[n + 1].kind != ROW_LIMIT);
        issue_command(directed_steps[n].item, directed_steps[n].kind == ROW_TYPED,
                      directed_steps[n].result, more, predicted);
      end
    end

    // Random part. Most commands follow the thread population: joins mostly name a live
    // thread, and wait, signal and broadcast mostly pass along one condition variable's
    // waiter mask so that threads really block and wake. The rest is noise.
    for (int p = 0; p < PHASES; p++) begin
      program_thread_limit(limit_plan[p]);
      no_idle = (p == 7);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        item.target = TID_W'($urandom);
        item.wmask = MASK_W'($urandom);
        uses_cv = 1'b0;
        if (roll < 18) begin
          item.command = CMD_CREATE;
        end else if (roll < 30) begin
          item.command = CMD_EXIT;
        end else if (roll < 46) begin
          item.command = CMD_JOIN;
          owned.delete();
          for (int s = 0; s < SLOTS; s++) if (alloc_q[s]) owned.push_back(TID_W'(s));
          if (owned.size() != 0 && $urandom_range(3) != 0)
            item.target = owned[$urandom_range(owned.size() - 1)];
        end else if (roll < 60) begin
          item.command = CMD_TICK;
        end else if (roll < 92) begin
          item.command = (roll < 72) ? CMD_WAIT : ((roll < 84) ? CMD_SIGNAL : CMD_BROADCAST);
          if ($urandom_range(9) < 7) begin
            item.wmask = waiter_set;
            uses_cv = 1'b1;
          end
        end else if (roll < 96) begin
          item.command = CMD_UNUSED;
        end else begin
          item.command = CMD_W'($urandom);
        end
        issue_command(item, 1'b0, '0, n + 1 < ITEMS_PER_PHASE, predicted);
        if (uses_cv) waiter_set = predicted.wmask;
      end
      no_idle = 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
